>>> design/bmu_pkg.sv
package bmu_pkg;

    localparam int DataW  = 64;
    localparam int ShW    = 6;
    localparam int CountW = 7;
    localparam int Bytes  = DataW / 8;

    typedef enum logic [3:0] {
        ACT_POPCOUNT = 4'd0,
        ACT_CLZ      = 4'd1,
        ACT_CTZ      = 4'd2,
        ACT_ROTL     = 4'd3,
        ACT_ROTR     = 4'd4,
        ACT_BITREV   = 4'd5,
        ACT_BYTEREV  = 4'd6,
        ACT_HIGHBIT  = 4'd7,
        ACT_LOWBIT   = 4'd8,
        ACT_SIGNUM   = 4'd9
    } t_action;

    function automatic logic [DataW-1:0] bit_reverse(input logic [DataW-1:0] x);
        logic [DataW-1:0] r;
        for (int i = 0; i < DataW; i++) begin
            r[i] = x[DataW-1-i];
        end
        return r;
    endfunction

    function automatic logic [DataW-1:0] byte_reverse(input logic [DataW-1:0] x);
        logic [DataW-1:0] r;
        for (int i = 0; i < Bytes; i++) begin
            r[8*i +: 8] = x[8*(Bytes-1-i) +: 8];
        end
        return r;
    endfunction

    // ones in one byte, 0..8
    function automatic logic [3:0] byte_popcount(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(b[i]);
        end
        return n;
    endfunction

    // leading zeros in one byte, 8 when the byte is zero
    function automatic logic [3:0] byte_lzc(input logic [7:0] b);
        logic [3:0] n;
        logic       hit;
        n   = 4'd8;
        hit = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!hit && b[i]) begin
                hit = 1'b1;
                n   = 4'(7 - i);
            end
        end
        return n;
    endfunction

endpackage

>>> design/bit_manipulation_unit_64.sv
// 64-bit bit manipulation unit.
// Command channel: drive i_action, i_operand and i_rotate_distance with start;
// a transfer happens at a rising edge where start is high and busy is low.
// Operations: popcount, clz, ctz, rotate left/right, bit reverse, byte
// reverse, isolate highest/lowest one bit, signum. Unused codes give zero.
// Result channel: o_result is shown for exactly one cycle with o_valid high,
// and is taken at the edge that ends that cycle. The receiver cannot stall,
// so the pipeline advances every cycle and never holds back.
// Pipeline: three register stages lie between the transfer and the result
// ports: operand prep and byte counts, byte summary and rotate, final select.
// Throughput: one transfer per cycle while busy is low, set by the three-stage pipeline.
// Reset: synchronous, active low; busy stays high while reset is asserted and
// until the ready register is set after release, and every valid bit is cleared.
// Results of items in flight at reset are dropped.
module bit_manipulation_unit_64
    import bmu_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [3:0]              i_action,
    input  logic signed [DataW-1:0] i_operand,
    input  logic [ShW-1:0]          i_rotate_distance,
    output logic                    o_valid,
    output logic signed [DataW-1:0] o_result
);

    // ---------------------------------------------------------------
    // Control: busy only in reset and while coming out of it
    // ---------------------------------------------------------------
    logic r_ready;
    logic n_take;

    assign busy   = !r_ready || !i_rst_n;
    assign n_take = start && !busy;

    // ---------------------------------------------------------------
    // Stage 1: decode, prepare the word for leading-zero search,
    // count ones per byte, finish the cheap operations
    // ---------------------------------------------------------------
    t_action          n_action;
    logic [DataW-1:0] n_x;
    logic [DataW-1:0] n_simple;
    logic [DataW-1:0] n_lzw;
    logic [ShW-1:0]   n_amt;

    logic             r_s1_valid;
    t_action          r_s1_action;
    logic [DataW-1:0] r_s1_simple;
    logic [DataW-1:0] r_s1_lzw;
    logic [3:0]       r_s1_pcb [Bytes];

    always_comb begin
        n_action = t_action'(i_action);
        n_x      = DataW'(i_operand);
        case (n_action)
            ACT_BITREV:  n_simple = bit_reverse(n_x);
            ACT_BYTEREV: n_simple = byte_reverse(n_x);
            ACT_LOWBIT:  n_simple = n_x & (~n_x + DataW'(1));
            ACT_SIGNUM: begin
                if (n_x == '0) begin
                    n_simple = '0;
                end else if (n_x[DataW-1]) begin
                    n_simple = '1;
                end else begin
                    n_simple = DataW'(1);
                end
            end
            default:     n_simple = '0;
        endcase
        // trailing zeros are the leading zeros of the reversed word
        n_lzw = (n_action == ACT_CTZ) ? bit_reverse(n_x) : n_x;
        // rotate right by d is rotate left by (64 - d) mod 64
        n_amt = (n_action == ACT_ROTR) ? (ShW'(0) - i_rotate_distance)
                                       : i_rotate_distance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready    <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_ready    <= 1'b1;
            r_s1_valid <= n_take;
        end
        r_s1_action <= n_action;
        r_s1_simple <= n_simple;
        r_s1_lzw    <= n_lzw;
        for (int i = 0; i < Bytes; i++) begin
            r_s1_pcb[i] <= byte_popcount(n_x[8*i +: 8]);
        end
    end

    // rotator spans stages 1 and 2
    logic [DataW-1:0] s2_rot;

    bmu_rot u_rot (
        .i_clk  (i_clk),
        .i_data (DataW'(i_operand)),
        .i_amt  (n_amt),
        .o_data (s2_rot)
    );

    // ---------------------------------------------------------------
    // Stage 2: add byte counts, summarize bytes for leading zeros
    // ---------------------------------------------------------------
    logic [CountW-1:0] n_pop;

    logic              r_s2_valid;
    t_action           r_s2_action;
    logic [DataW-1:0]  r_s2_simple;
    logic [CountW-1:0] r_s2_pop;
    logic [3:0]        r_s2_blz [Bytes];
    logic [Bytes-1:0]  r_s2_bnz;

    always_comb begin
        n_pop = '0;
        for (int i = 0; i < Bytes; i++) begin
            n_pop = n_pop + CountW'(r_s1_pcb[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_action <= r_s1_action;
        r_s2_simple <= r_s1_simple;
        r_s2_pop    <= n_pop;
        for (int i = 0; i < Bytes; i++) begin
            r_s2_blz[i] <= byte_lzc(r_s1_lzw[8*i +: 8]);
            r_s2_bnz[i] <= |r_s1_lzw[8*i +: 8];
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: pick the first nonzero byte, form the count, select result
    // ---------------------------------------------------------------
    logic [CountW-1:0] n_lz;
    logic              n_hit;
    logic [DataW-1:0]  n_high;
    logic [DataW-1:0]  n_result;

    logic              r_valid;
    logic [DataW-1:0]  r_result;

    always_comb begin
        n_lz  = CountW'(DataW);
        n_hit = 1'b0;
        for (int i = Bytes - 1; i >= 0; i--) begin
            if (!n_hit && r_s2_bnz[i]) begin
                n_hit = 1'b1;
                n_lz  = CountW'((Bytes - 1 - i) * 8) + CountW'(r_s2_blz[i]);
            end
        end
        n_high = n_hit ? (DataW'(1) << (ShW'(DataW - 1) - n_lz[ShW-1:0])) : '0;
        case (r_s2_action)
            ACT_POPCOUNT:      n_result = DataW'(r_s2_pop);
            ACT_CLZ, ACT_CTZ:  n_result = DataW'(n_lz);
            ACT_ROTL, ACT_ROTR: n_result = s2_rot;
            ACT_HIGHBIT:       n_result = n_high;
            default:           n_result = r_s2_simple;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_s2_valid;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef SYNTH
    // every result strobe traces back to a matching transfer
    a_valid_from_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 3))
        else $error("result strobe without matching transfer");

    // signum gives only -1, 0 or 1
    a_signum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_action == ACT_SIGNUM, 3))
        |-> (o_result == '0 || o_result == DataW'(1) || (&o_result)))
        else $error("signum result out of range");

    // isolating one bit yields at most one set bit
    a_isolate_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_action == ACT_LOWBIT, 3) || $past(i_action == ACT_HIGHBIT, 3)))
        |-> $onehot0(o_result))
        else $error("isolated bit result has more than one bit set");
`endif

endmodule

>>> design/bmu_rot.sv
module bmu_rot
    import bmu_pkg::*;
(
    input  logic             i_clk,
    input  logic [DataW-1:0] i_data,
    input  logic [ShW-1:0]   i_amt,
    output logic [DataW-1:0] o_data
);

    logic [DataW-1:0]   r_coarse;
    logic [2:0]         r_fine;
    logic [DataW-1:0]   r_data;
    logic [2*DataW-1:0] n_coarse_w;
    logic [2*DataW-1:0] n_fine_w;

    // coarse step rotates by whole bytes, fine step by the remaining bits
    always_comb begin
        n_coarse_w = {i_data, i_data} << {i_amt[ShW-1:3], 3'b000};
        n_fine_w   = {r_coarse, r_coarse} << r_fine;
    end

    always_ff @(posedge i_clk) begin
        r_coarse <= n_coarse_w[2*DataW-1:DataW];
        r_fine   <= i_amt[2:0];
        r_data   <= n_fine_w[2*DataW-1:DataW];
    end

    assign o_data = r_data;

endmodule
